@@ src/lkv_pkg.sv @@
// Shared types and constants for the LRU key/value cache.
// No dependencies; imported by every module of the block.
package lkv_pkg;

    // Fixed field widths of the item and result ports
    localparam int KEY_W  = 64;
    localparam int DATA_W = 64;
    localparam int CAP_W  = 5;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Op queue between the front and the back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } lkv_cmd_t;

    // Classified operation handed from the front to the back
    typedef struct packed
    {
        lkv_cmd_t           cmd;
        logic               hit;
        logic               evict;
        logic [KEY_W-1:0]   key;
        logic [KEY_W-1:0]   evict_key;
        logic [DATA_W-1:0]  value;
    } lkv_op_t;

endpackage

@@ src/lkv_queue.sv @@
// Two-entry FIFO that carries classified ops from the front to the back.
// Depends on lkv_pkg for the depth constants.
module lkv_queue
    import lkv_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0]   slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg;
    logic [Q_CNT_W-1:0] cnt_next;
    logic               do_push;
    logic               do_pop;

    assign empty   = (cnt_reg == '0);
    assign do_push = push && (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + Q_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + Q_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ src/lkv_front.sv @@
// Front end: holds one incoming item, matches its key against all entries
// and classifies it (hit, eviction, target slot). Depends on lkv_pkg.
module lkv_front
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16,
    localparam int IDX_W = $clog2(ENTRIES),
    localparam int CNT_W = $clog2(ENTRIES + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    // item channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [KEY_W-1:0]  lookup_key,
    input  logic [DATA_W-1:0] write_value,
    // configuration and committed state
    input  logic [CAP_W-1:0]  capacity,
    input  logic [ENTRIES-1:0] valid_vec,
    input  logic [KEY_W-1:0]  keys [ENTRIES],
    input  logic [IDX_W-1:0]  ranks [ENTRIES],
    input  logic [CNT_W-1:0]  entry_count,
    // op queue
    input  logic              q_empty,
    output logic              push,
    output lkv_op_t           op,
    output logic [IDX_W-1:0]  op_slot,
    output logic [IDX_W-1:0]  op_evict_slot,
    output logic [IDX_W-1:0]  op_touch_rank
);

    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic              in_valid_reg;
    lkv_cmd_t          cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] value_reg;
    logic              accept;

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] lru_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] free_low;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   lru_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   hit_rank;
    logic               hit;
    logic               is_write;
    logic               evict;
    logic [CMP_W-1:0]   cap_ext;
    logic [CNT_W-1:0]   cap_eff;
    logic [CNT_W-1:0]   cnt_m1;
    logic [CNT_W-1:0]   cnt_m2;
    logic [CNT_W-1:0]   lru_target;

    // Hold one item; the next lookup waits until the back has committed
    assign push     = in_valid_reg && q_empty;
    assign in_stall = in_valid_reg && !push;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= lkv_cmd_t'(cmd);
            key_reg   <= lookup_key;
            value_reg <= write_value;
        end
    end

    // Effective capacity: zero counts as one, saturate at ENTRIES
    always_comb
    begin
        cap_ext = CMP_W'(capacity);
        if (cap_ext == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            cap_eff = CNT_W'(ENTRIES);
        end
        else
        begin
            cap_eff = CNT_W'(cap_ext);
        end
    end

    assign is_write = (cmd_reg == CMD_WRITE);
    assign cnt_m1   = entry_count - CNT_W'(1);
    assign cnt_m2   = entry_count - CNT_W'(2);

    // Key match across all entries; keys of valid entries are distinct
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = valid_vec[i] && (keys[i] == key_reg);
            if (match_vec[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign hit      = |match_vec;
    assign hit_rank = ranks[hit_idx];

    // LRU entry holds the highest rank; when a write hit moves the last
    // entry to the front, the one before it becomes least recent
    always_comb
    begin
        if (is_write && hit && (CNT_W'(hit_rank) == cnt_m1))
        begin
            lru_target = cnt_m2;
        end
        else
        begin
            lru_target = cnt_m1;
        end
    end

    always_comb
    begin
        lru_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            lru_vec[i] = valid_vec[i] && (CNT_W'(ranks[i]) == lru_target);
            if (lru_vec[i])
            begin
                lru_idx = lru_idx | IDX_W'(i);
            end
        end
    end

    // Lowest free slot
    assign free_vec = ~valid_vec;
    assign free_low = free_vec & (~free_vec + ENTRIES'(1));

    always_comb
    begin
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (free_low[i])
            begin
                free_idx = free_idx | IDX_W'(i);
            end
        end
    end

    // Eviction decision
    always_comb
    begin
        priority if (!is_write)
        begin
            evict = 1'b0;
        end
        else if (hit)
        begin
            evict = (entry_count > cap_eff);
        end
        else
        begin
            evict = (entry_count >= cap_eff);
        end
    end

    // Classified op
    always_comb
    begin
        op.cmd       = cmd_reg;
        op.hit       = hit;
        op.evict     = evict;
        op.key       = key_reg;
        op.value     = value_reg;
        op.evict_key = evict ? keys[lru_idx] : '0;
        op_evict_slot = lru_idx;
        priority if (hit)
        begin
            op_slot       = hit_idx;
            op_touch_rank = hit_rank;
        end
        else if (evict)
        begin
            op_slot       = lru_idx;
            op_touch_rank = cnt_m1[IDX_W-1:0];
        end
        else
        begin
            op_slot       = free_idx;
            op_touch_rank = entry_count[IDX_W-1:0];
        end
    end

endmodule

@@ src/lkv_back.sv @@
// Back end: applies classified ops to the entry state (keys, values,
// valid bits, recency ranks) and drives the result register. Uses lkv_pkg.
module lkv_back
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int VALUE_BITS = 64,
    localparam int IDX_W = $clog2(ENTRIES),
    localparam int CNT_W = $clog2(ENTRIES + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    // op queue
    input  logic              q_empty,
    output logic              pop,
    input  lkv_op_t           op,
    input  logic [IDX_W-1:0]  op_slot,
    input  logic [IDX_W-1:0]  op_evict_slot,
    input  logic [IDX_W-1:0]  op_touch_rank,
    // committed state for the front
    output logic [ENTRIES-1:0] valid_vec,
    output logic [KEY_W-1:0]  keys [ENTRIES],
    output logic [IDX_W-1:0]  ranks [ENTRIES],
    output logic [CNT_W-1:0]  entry_count,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    output logic [DATA_W-1:0] read_value,
    output logic              evicted,
    output logic [KEY_W-1:0]  evicted_key
);

    logic [ENTRIES-1:0]    valid_reg;
    logic [ENTRIES-1:0]    valid_next;
    logic [IDX_W-1:0]      rank_reg [ENTRIES];
    logic [IDX_W-1:0]      rank_next [ENTRIES];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [KEY_W-1:0]      key_reg [ENTRIES];
    logic [VALUE_BITS-1:0] value_mem [ENTRIES];
    logic [VALUE_BITS-1:0] rd_data_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              hit_reg;
    logic              rd_sel_reg;
    logic              evicted_reg;
    logic [KEY_W-1:0]  evicted_key_reg;

    logic is_write;
    logic touch;
    logic insert;
    logic drop;

    // Take an op whenever the result register is free or being drained
    assign pop      = !q_empty && (!out_valid_reg || !out_stall);
    assign is_write = (op.cmd == CMD_WRITE);
    assign touch    = op.hit || is_write;
    assign insert   = is_write && !op.hit;
    assign drop     = is_write && op.hit && op.evict;

    // Recency and valid update: entries more recent than the touched rank
    // age by one, the target slot becomes most recent
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i]  = rank_reg[i];
            valid_next[i] = valid_reg[i];
            if (pop && touch)
            begin
                if (valid_reg[i] && (rank_reg[i] < op_touch_rank))
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
                if (IDX_W'(i) == op_slot)
                begin
                    rank_next[i] = '0;
                end
            end
            if (pop && insert && (IDX_W'(i) == op_slot))
            begin
                valid_next[i] = 1'b1;
            end
            if (pop && drop && (IDX_W'(i) == op_evict_slot))
            begin
                valid_next[i] = 1'b0;
            end
        end
    end

    // Entry count
    always_comb
    begin
        count_next = count_reg;
        if (pop && insert && !op.evict)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && drop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Key store, compared in parallel by the front
    always_ff @(posedge clk)
    begin
        if (pop && insert)
        begin
            key_reg[op_slot] <= op.key;
        end
    end

    // Value memory with registered read
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (is_write)
            begin
                value_mem[op_slot] <= op.value[VALUE_BITS-1:0];
            end
            rd_data_reg <= value_mem[op_slot];
        end
    end

    // Result register
    always_comb
    begin
        priority if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hit_reg         <= op.hit;
            rd_sel_reg      <= op.hit && !is_write;
            evicted_reg     <= op.evict;
            evicted_key_reg <= op.evict_key;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign read_value  = rd_sel_reg ? DATA_W'(rd_data_reg) : '0;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    assign valid_vec   = valid_reg;
    assign keys        = key_reg;
    assign ranks       = rank_reg;
    assign entry_count = count_reg;

endmodule

@@ src/lru_key_value_cache.sv @@
// Top level of the LRU key/value cache: capacity register, front end,
// op queue and back end. Depends on lkv_pkg, lkv_front, lkv_queue, lkv_back.
//
// Usage:
//   Item channel (in_valid / in_stall): cmd 0 writes write_value under
//   lookup_key, cmd 1 reads lookup_key. A transfer happens on a clock edge
//   with in_valid high and in_stall low.
//   Result channel (out_valid / out_stall): one result per item, in order:
//   hit, read_value (read hits only), evicted and evicted_key (writes that
//   pushed out the least recent entry).
//   Config channel (cfg_valid / cfg_ready): writes the capacity register;
//   cfg_ready is always high. Write it only while the cache is idle.
// Flow:
//   Each item passes the front end register, op queue and result register.
//   A new item is taken as the held one is queued; its lookup waits for the
//   back end to commit the recency and valid update of the item before it.
// Reset clears all valid bits, ranks and the entry count and loads
// capacity 16; the cache accepts items right after reset.
// While out_stall is high the result holds, the back end stops, and the
// front end holds at most one more classified item plus one waiting item.
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int VALUE_BITS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CAP_W-1:0]  capacity,
    // items
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [KEY_W-1:0]  lookup_key,
    input  logic [DATA_W-1:0] write_value,
    // results
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    output logic [DATA_W-1:0] read_value,
    output logic              evicted,
    output logic [KEY_W-1:0]  evicted_key
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int Q_W   = $bits(lkv_op_t) + 3 * IDX_W;

    logic [CAP_W-1:0]   capacity_reg;

    logic [ENTRIES-1:0] valid_vec;
    logic [KEY_W-1:0]   keys [ENTRIES];
    logic [IDX_W-1:0]   ranks [ENTRIES];
    logic [CNT_W-1:0]   entry_count;

    logic               q_push;
    logic               q_pop;
    logic               q_empty;
    logic [Q_W-1:0]     q_wdata;
    logic [Q_W-1:0]     q_rdata;

    lkv_op_t            f_op;
    logic [IDX_W-1:0]   f_slot;
    logic [IDX_W-1:0]   f_evict_slot;
    logic [IDX_W-1:0]   f_touch_rank;
    lkv_op_t            b_op;
    logic [IDX_W-1:0]   b_slot;
    logic [IDX_W-1:0]   b_evict_slot;
    logic [IDX_W-1:0]   b_touch_rank;

    // Capacity register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= capacity;
        end
    end

    lkv_front #(
        .ENTRIES (ENTRIES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .lookup_key    (lookup_key),
        .write_value   (write_value),
        .capacity      (capacity_reg),
        .valid_vec     (valid_vec),
        .keys          (keys),
        .ranks         (ranks),
        .entry_count   (entry_count),
        .q_empty       (q_empty),
        .push          (q_push),
        .op            (f_op),
        .op_slot       (f_slot),
        .op_evict_slot (f_evict_slot),
        .op_touch_rank (f_touch_rank)
    );

    assign q_wdata = {f_op, f_slot, f_evict_slot, f_touch_rank};

    lkv_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign {b_op, b_slot, b_evict_slot, b_touch_rank} = q_rdata;

    lkv_back #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .pop           (q_pop),
        .op            (b_op),
        .op_slot       (b_slot),
        .op_evict_slot (b_evict_slot),
        .op_touch_rank (b_touch_rank),
        .valid_vec     (valid_vec),
        .keys          (keys),
        .ranks         (ranks),
        .entry_count   (entry_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .read_value    (read_value),
        .evicted       (evicted),
        .evicted_key   (evicted_key)
    );

    // A lookup must only run against fully committed state
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_empty)
        else $error("front classified an item while an op was pending");

    // Entry count tracks the valid bits
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(entry_count))
        else $error("entry count out of step with valid bits");

    // Value only on a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> read_value == '0)
        else $error("read value nonzero on a miss");

    // Evicted key only with an eviction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> evicted_key == '0)
        else $error("evicted key nonzero without an eviction");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for lru_key_value_cache: directed table, then random accesses.
// Depends on lkv_pkg and the lru_key_value_cache RTL; needs no other files.
module tb_top;
    import lkv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  SLOTS       = 16;
    localparam int  PHASES      = 8;
    localparam int  PHASE_ITEMS = 204;
    localparam int  POOL_SIZE   = 24;
    localparam int  MAX_REPORTS = 10;
    localparam real TIMEOUT_NS  = 4_000_000.0;

    // Special key and value patterns for the directed table
    localparam logic [KEY_W-1:0] K_LOW  = 64'h0000_0000_0000_0000;
    localparam logic [KEY_W-1:0] K_HIGH = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] K_MID  = 64'h0123_4567_89AB_CDEF;
    localparam logic [KEY_W-1:0] K_A    = 64'hDEAD_BEEF_0000_0001;
    localparam logic [KEY_W-1:0] K_B    = 64'h8000_0000_0000_0000;
    localparam logic [KEY_W-1:0] K_C    = 64'h0000_0000_0000_0001;
    localparam logic [KEY_W-1:0] K_D    = 64'hFEDC_BA98_7654_3210;

    typedef struct packed
    {
        logic              hit;
        logic [DATA_W-1:0] rval;
        logic              ev;
        logic [KEY_W-1:0]  evkey;
    } access_result_t;

    typedef enum logic
    {
        ROW_ACCESS   = 1'b0,
        ROW_CAPACITY = 1'b1
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t          kind;
        logic [CAP_W-1:0]   cap_value;
        lkv_cmd_t           op;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  value;
        logic               typed;
        access_result_t     want;
    } dir_row_t;

    localparam access_result_t NO_RESULT = '{1'b0, 64'h0, 1'b0, 64'h0};

    // DUT ports
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CAP_W-1:0]  capacity = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              cmd = 1'b0;
    logic [KEY_W-1:0]  lookup_key = '0;
    logic [DATA_W-1:0] write_value = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;

    // Shadow copy of the cache contents and recency order
    logic [KEY_W-1:0]  shadow_key   [SLOTS];
    logic [DATA_W-1:0] shadow_value [SLOTS];
    logic              shadow_used  [SLOTS];
    int unsigned       shadow_age   [SLOTS];
    logic [CAP_W-1:0]  shadow_capacity;

    access_result_t pending_results [$];
    int             mismatch_count = 0;
    int             send_idle_pct = 0;
    int             stall_pct = 0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    // Directed table: typed rows are accesses off reset state, extremes and
    // the zero capacity case; the rest go through the shadow model.
    dir_row_t directed_rows [22] = '{
        '{ROW_ACCESS, 5'd0, CMD_READ, K_LOW, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, NO_RESULT},
        '{ROW_ACCESS, 5'd0, CMD_WRITE, K_LOW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, NO_RESULT},
        '{ROW_ACCESS, 5'd0, CMD_READ, K_LOW, 64'h0, 1'b1,
          '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0}},
        '{ROW_ACCESS, 5'd0, CMD_WRITE, K_HIGH, 64'h0, 1'b1, NO_RESULT},
        '{ROW_ACCESS, 5'd0, CMD_WRITE, K_LOW, 64'h5555_5555_5555_5555, 1'b1,
          '{1'b1, 64'h0, 1'b0, 64'h0}},
        '{ROW_ACCESS, 5'd0, CMD_READ, K_HIGH, 64'h0, 1'b1, '{1'b1, 64'h0, 1'b0, 64'h0}},
        // zero capacity acts as one, with two entries held
        '{ROW_CAPACITY, 5'd0, CMD_READ, K_LOW, 64'h0, 1'b0, NO_RESULT},
        '{ROW_ACCESS, 5'd0, CMD_WRITE, K_LOW, 64'h1, 1'b1, '{1'b1, 64'h0, 1'b1, K_HIGH}},
        '{ROW_ACCESS, 5'd0, CMD_WRITE, K_MID, 64'h2, 1'b1, '{1'b0, 64'h0, 1'b1, K_LOW}},
        '{ROW_ACCESS, 5'd0, CMD_READ, K_LOW, 64'h0, 1'b1, NO_RESULT},
        '{ROW_ACCESS, 5'd0, CMD_READ, K_MID, 64'h0, 1'b1, '{1'b1, 64'h2, 1'b0, 64'h0}},
        '{ROW_CAPACITY, 5'd2, CMD_READ, K_LOW, 64'h0, 1'b0, NO_RESULT},
        '{ROW_ACCESS, 5'd0, CMD_WRITE, K_A, 64'h1111_1111_1111_1111, 1'b0, NO_RESULT},
        '{ROW_ACCESS, 5'd0, CMD_WRITE, K_B, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_ACCESS, 5'd0, CMD_READ, K_A, 64'h0, 1'b0, NO_RESULT},
        '{ROW_ACCESS, 5'd0, CMD_WRITE, K_C, 64'h8000_0000_0000_0001, 1'b0, NO_RESULT},
        // out-of-range capacity saturates to the slot count
        '{ROW_CAPACITY, 5'd31, CMD_READ, K_LOW, 64'h0, 1'b0, NO_RESULT},
        '{ROW_ACCESS, 5'd0, CMD_WRITE, K_D, 64'h3, 1'b0, NO_RESULT},
        '{ROW_ACCESS, 5'd0, CMD_READ, K_B, 64'h0, 1'b0, NO_RESULT},
        '{ROW_ACCESS, 5'd0, CMD_WRITE, K_A, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_CAPACITY, 5'd16, CMD_READ, K_LOW, 64'h0, 1'b0, NO_RESULT},
        '{ROW_ACCESS, 5'd0, CMD_READ, K_C, 64'h0, 1'b0, NO_RESULT}
    };

    // Idle and stall percentages per phase: none, sender, receiver, both
    int send_pct_by_mode  [4] = '{0, 70, 0, 15};
    int stall_pct_by_mode [4] = '{0, 0, 70, 15};
    logic [CAP_W-1:0] phase_capacity [PHASES] =
        '{5'd1, 5'd4, 5'd16, 5'd31, 5'd0, 5'd8, 5'd2, 5'd12};

    lru_key_value_cache i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .capacity    (capacity),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Valid slot with the highest age, -1 when empty
    function automatic int shadow_oldest();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (shadow_used[i] && (best < 0 || shadow_age[i] > shadow_age[best]))
                best = i;
        return best;
    endfunction

    // Move a valid slot to the front of the recency order
    function automatic void shadow_promote(int slot);
        int unsigned r;
        r = shadow_age[slot];
        for (int i = 0; i < SLOTS; i++)
            if (shadow_used[i] && shadow_age[i] < r)
                shadow_age[i]++;
        shadow_age[slot] = 0;
    endfunction

    // Apply one access to the shadow cache and return what the DUT must report
    function automatic access_result_t predict_access(lkv_cmd_t op,
                                                      logic [KEY_W-1:0] key,
                                                      logic [DATA_W-1:0] value);
        access_result_t res;
        int found;
        int victim;
        int dst;
        int used_count;
        int limit;
        res = NO_RESULT;
        found = -1;
        dst = -1;
        used_count = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_used[i])
                used_count++;
            if (found < 0 && shadow_used[i] && shadow_key[i] == key)
                found = i;
        end
        if (shadow_capacity == 0)
            limit = 1;
        else if (shadow_capacity > SLOTS)
            limit = SLOTS;
        else
            limit = int'(shadow_capacity);

        if (op == CMD_READ)
        begin
            // a miss leaves the order untouched
            if (found >= 0)
            begin
                res.hit = 1'b1;
                res.rval = shadow_value[found];
                shadow_promote(found);
            end
        end
        else if (found >= 0)
        begin
            // overwrite; trims one entry if capacity was lowered below the count
            res.hit = 1'b1;
            shadow_value[found] = value;
            shadow_promote(found);
            if (used_count > limit)
            begin
                victim = shadow_oldest();
                if (victim >= 0 && victim != found)
                begin
                    res.ev = 1'b1;
                    res.evkey = shadow_key[victim];
                    shadow_used[victim] = 1'b0;
                end
            end
        end
        else
        begin
            // new key: evict the oldest when full, its slot takes the key
            if (used_count >= limit)
            begin
                victim = shadow_oldest();
                if (victim >= 0)
                begin
                    res.ev = 1'b1;
                    res.evkey = shadow_key[victim];
                    shadow_used[victim] = 1'b0;
                    dst = victim;
                end
            end
            if (dst < 0)
                for (int i = 0; i < SLOTS; i++)
                    if (!shadow_used[i] && dst < 0)
                        dst = i;
            if (dst >= 0)
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (shadow_used[i])
                        shadow_age[i]++;
                shadow_key[dst] = key;
                shadow_value[dst] = value;
                shadow_used[dst] = 1'b1;
                shadow_age[dst] = 0;
            end
        end
        return res;
    endfunction

    // Offer one access, wait for its transfer, queue the expected result
    task automatic push_access(input lkv_cmd_t op, input logic [KEY_W-1:0] key,
                               input logic [DATA_W-1:0] value, input logic typed,
                               input access_result_t want);
        access_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            cmd <= 1'($urandom_range(1));
            lookup_key <= {$urandom, $urandom};
            write_value <= {$urandom, $urandom};
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        lookup_key <= key;
        write_value <= value;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_access(op, key, value);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Capacity write, only once all outstanding results are back
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        capacity <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_capacity = value;
    endtask

    // Receiver back-pressure
    always @(posedge clk)
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);

    // Result checker
    always @(posedge clk)
    begin
        access_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with nothing pending: hit=%0b rv=%h ev=%0b ek=%h",
                             $realtime, hit, read_value, evicted, evicted_key);
            end
            else
            begin
                want = pending_results.pop_front();
                if (hit !== want.hit || read_value !== want.rval ||
                    evicted !== want.ev || evicted_key !== want.evkey)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: exp hit=%0b rv=%h ev=%0b ek=%h", $realtime,
                                 want.hit, want.rval, want.ev, want.evkey);
                        $display("%0t: got hit=%0b rv=%h ev=%0b ek=%h", $realtime,
                                 hit, read_value, evicted, evicted_key);
                    end
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int pool_used;
        int limit;
        lkv_cmd_t op;
        logic [KEY_W-1:0] key;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_key[i] = '0;
            shadow_value[i] = '0;
            shadow_used[i] = 1'b0;
            shadow_age[i] = 0;
        end
        shadow_capacity = CAP_RESET;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CAPACITY)
                write_capacity(directed_rows[r].cap_value);
            else
                push_access(directed_rows[r].op, directed_rows[r].key,
                            directed_rows[r].value, directed_rows[r].typed,
                            directed_rows[r].want);
        end

        // random phases, each with its own capacity and idling mode
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_capacity[p]);
            send_idle_pct = send_pct_by_mode[p % 4];
            stall_pct = stall_pct_by_mode[p % 4];
            limit = (phase_capacity[p] == 0) ? 1 :
                    (phase_capacity[p] > SLOTS) ? SLOTS : int'(phase_capacity[p]);
            // a key set slightly larger than the capacity gives a mix of hits and evictions
            pool_used = limit + 1 + $urandom_range(4);
            if (pool_used > POOL_SIZE)
                pool_used = POOL_SIZE;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                op = ($urandom_range(99) < 40) ? CMD_READ : CMD_WRITE;
                if ($urandom_range(9) == 0)
                    key = {$urandom, $urandom};
                else
                    key = key_pool[$urandom_range(pool_used - 1)];
                push_access(op, key, {$urandom, $urandom}, 1'b0, NO_RESULT);
            end
        end

        // drain
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("lru_key_value_cache: match");
        else
            $display("lru_key_value_cache: mismatch");
        $finish;
    end

    // Run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("lru_key_value_cache: mismatch");
        $finish;
    end

endmodule
